// ===== src/multicolor_pixel_plot_top_defines.svh =====
// assertion macros shared by the plotter rtl
`ifndef MULTICOLOR_PIXEL_PLOT_TOP_DEFINES_SVH
`define MULTICOLOR_PIXEL_PLOT_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MPP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpp assertion failed");

// next-cycle implication, checked out of reset
`define MPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpp assertion failed");

`endif

// ===== src/mpp_pkg.sv =====
// types, constants and address helpers for the multicolor pixel plotter
package mpp_pkg;

    localparam int PIXEL_WIDTH  = 160;
    localparam int PIXEL_HEIGHT = 192;

    localparam int BITMAP_DEPTH = 8192;
    localparam int CELL_DEPTH   = 1024;
    localparam int BITMAP_AW    = $clog2(BITMAP_DEPTH);
    localparam int CELL_AW      = $clog2(CELL_DEPTH);

    // cell word: color entry in the upper six bits, screen byte below
    localparam int CELL_WORD_W  = 14;

    localparam logic [5:0] FLAG_LOW  = 6'h10;
    localparam logic [5:0] FLAG_HIGH = 6'h20;
    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    localparam logic FUNC_PLOT = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [1:0] CODE_BG   = 2'd0;
    localparam logic [1:0] CODE_HIGH = 2'd1;
    localparam logic [1:0] CODE_LOW  = 2'd2;
    localparam logic [1:0] CODE_CELL = 2'd3;

    typedef struct packed {
        logic       func;
        logic [7:0] x;
        logic [7:0] y;
        logic [3:0] color;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  pixel_code;
        logic [12:0] bitmap_index;
        logic [7:0]  bitmap_byte;
        logic [9:0]  cell_index;
        logic [7:0]  screen_byte;
        logic [5:0]  color_byte;
        logic        screen_written;
        logic        color_written;
    } result_t;

    // (x/4)*8 + (y/8)*320 + y%8
    function automatic logic [BITMAP_AW-1:0] bitmap_index(input logic [7:0] x,
                                                          input logic [7:0] y);
        logic [BITMAP_AW-1:0] col_part;
        logic [BITMAP_AW-1:0] row_part;
        col_part = BITMAP_AW'({x[7:2], 3'b000});
        row_part = BITMAP_AW'({y[7:3], 8'h00}) + BITMAP_AW'({y[7:3], 6'h00});
        return col_part + row_part + BITMAP_AW'(y[2:0]);
    endfunction

    // x/4 + (y/8)*40
    function automatic logic [CELL_AW-1:0] cell_index(input logic [7:0] x,
                                                      input logic [7:0] y);
        logic [CELL_AW-1:0] row_part;
        row_part = CELL_AW'({y[7:3], 5'h00}) + CELL_AW'({y[7:3], 3'h0});
        return CELL_AW'(x[7:2]) + row_part;
    endfunction

    // leftmost pixel sits in bits 7-6
    function automatic logic [2:0] pixel_shift(input logic [1:0] sub_x);
        logic [2:0] sh;
        case (sub_x)
            2'd0:    sh = 3'd6;
            2'd1:    sh = 3'd4;
            2'd2:    sh = 3'd2;
            default: sh = 3'd0;
        endcase
        return sh;
    endfunction

endpackage

// ===== src/mpp_ram.sv =====
// generic single-port-write, registered-read ram
module mpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/multicolor_pixel_plot_top.sv =====
// top level: multicolor pixel plotter over bitmap and cell rams
// result: the item is registered on acceptance, and the result is registered as exec completes once the output is free
// new items are stalled until the current one completes its ram read then write-back
// an out-of-screen item goes through the same states and writes nothing
// reset: a clearing pass over all 8192 bitmap addresses zeroes both rams, items stalled meanwhile
// background color resets to zero; config writes wait until no item is in exec and no result is pending
`include "multicolor_pixel_plot_top_defines.svh"

module multicolor_pixel_plot_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  mpp_pkg::item_t     item,
    output logic               result_valid,
    input  logic               result_stall,
    output mpp_pkg::result_t   result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [mpp_pkg::BITMAP_AW-1:0] clr_addr_reg, clr_addr_next;
    logic [3:0] bg_reg;
    logic       out_valid_reg, out_valid_next;
    mpp_pkg::result_t out_reg, out_next;
    mpp_pkg::item_t   item_reg;
    logic       inside_reg;
    logic [mpp_pkg::BITMAP_AW-1:0] bidx_reg;
    logic [mpp_pkg::CELL_AW-1:0]   cidx_reg;

    logic accept;
    logic inside_in;
    logic [mpp_pkg::BITMAP_AW-1:0] bidx_in;
    logic [mpp_pkg::CELL_AW-1:0]   cidx_in;

    logic [mpp_pkg::BITMAP_AW-1:0] bm_raddr, bm_waddr;
    logic [7:0] bm_rdata, bm_wdata;
    logic       bm_we;
    logic [mpp_pkg::CELL_AW-1:0] cell_raddr, cell_waddr;
    logic [mpp_pkg::CELL_WORD_W-1:0] cell_rdata, cell_wdata;
    logic       cell_we;

    logic out_free;
    logic done;

    logic [7:0] scol, scol_new;
    logic [5:0] ccol, ccol_new;
    logic [7:0] b_new;
    logic [7:0] b_shifted;
    logic [2:0] sh;
    logic [1:0] code;
    logic       sw, cw;
    logic       is_plot, is_bg;

    assign accept     = item_valid && !item_stall;
    // a pending config write holds off new items
    assign item_stall = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready  = (state_reg != S_EXEC) && !out_valid_reg;

    assign inside_in = (item.x < 8'(mpp_pkg::PIXEL_WIDTH))
                    && (item.y < 8'(mpp_pkg::PIXEL_HEIGHT));
    assign bidx_in   = mpp_pkg::bitmap_index(item.x, item.y);
    assign cidx_in   = mpp_pkg::cell_index(item.x, item.y);

    // hold the read address during exec so read data stays put while stalled
    assign bm_raddr   = (state_reg == S_IDLE) ? bidx_in : bidx_reg;
    assign cell_raddr = (state_reg == S_IDLE) ? cidx_in : cidx_reg;

    assign out_free = !out_valid_reg || !result_stall;
    assign done     = (state_reg == S_EXEC) && out_free;

    // read-modify-write of one pixel
    always_comb
    begin
        scol      = cell_rdata[7:0];
        ccol      = cell_rdata[13:8];
        scol_new  = scol;
        ccol_new  = ccol;
        sh        = mpp_pkg::pixel_shift(item_reg.x[1:0]);
        b_shifted = bm_rdata >> sh;
        is_plot   = (item_reg.func == mpp_pkg::FUNC_PLOT);
        is_bg     = (item_reg.color == bg_reg);
        sw        = 1'b0;
        cw        = 1'b0;
        code      = b_shifted[1:0];
        if (is_plot)
        begin
            if (is_bg)
            begin
                code = mpp_pkg::CODE_BG;
            end
            else
            begin
                cw = 1'b1;
                if ((item_reg.color == (scol[3:0] & mpp_pkg::NIBBLE_MASK))
                    || ((ccol & mpp_pkg::FLAG_LOW) == 6'd0))
                begin
                    code     = mpp_pkg::CODE_LOW;
                    scol_new = {scol[7:4], item_reg.color};
                    ccol_new = ccol | mpp_pkg::FLAG_LOW;
                    sw       = 1'b1;
                end
                else if ((item_reg.color == scol[7:4])
                         || ((ccol & mpp_pkg::FLAG_HIGH) == 6'd0))
                begin
                    code     = mpp_pkg::CODE_HIGH;
                    scol_new = {item_reg.color, scol[3:0]};
                    ccol_new = ccol | mpp_pkg::FLAG_HIGH;
                    sw       = 1'b1;
                end
                else
                begin
                    code     = mpp_pkg::CODE_CELL;
                    ccol_new = mpp_pkg::FLAG_LOW | mpp_pkg::FLAG_HIGH | {2'b00, item_reg.color};
                end
            end
        end
        b_new = is_plot ? ((bm_rdata & ~(8'h03 << sh)) | (8'({code}) << sh)) : bm_rdata;
    end

    // ram write ports: zero sweep while clearing, write-back on completion
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            bm_we      = 1'b1;
            bm_waddr   = clr_addr_reg;
            bm_wdata   = 8'h00;
            cell_we    = 1'b1;
            cell_waddr = clr_addr_reg[mpp_pkg::CELL_AW-1:0];
            cell_wdata = '0;
        end
        else
        begin
            bm_we      = done && inside_reg && is_plot;
            bm_waddr   = bidx_reg;
            bm_wdata   = b_new;
            cell_we    = done && inside_reg && cw;
            cell_waddr = cidx_reg;
            cell_wdata = {ccol_new, scol_new};
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (done)
        begin
            if (inside_reg)
            begin
                out_next.accepted       = 1'b1;
                out_next.pixel_code     = code;
                out_next.bitmap_index   = bidx_reg;
                out_next.bitmap_byte    = b_new;
                out_next.cell_index     = cidx_reg;
                out_next.screen_byte    = scol_new;
                out_next.color_byte     = ccol_new;
                out_next.screen_written = sw;
                out_next.color_written  = cw;
            end
            else
            begin
                out_next = '0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == mpp_pkg::BITMAP_AW'(mpp_pkg::BITMAP_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            bg_reg        <= 4'h0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                bg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept)
        begin
            item_reg   <= item;
            inside_reg <= inside_in;
            bidx_reg   <= bidx_in;
            cidx_reg   <= cidx_in;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    mpp_ram #(
        .WIDTH (8),
        .DEPTH (mpp_pkg::BITMAP_DEPTH)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    mpp_ram #(
        .WIDTH (mpp_pkg::CELL_WORD_W),
        .DEPTH (mpp_pkg::CELL_DEPTH)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    `MPP_ASSERT_IMP(a_no_item_while_clearing, state_reg == S_CLEAR, item_stall)
    `MPP_ASSERT_NEXT(a_accept_goes_exec, accept, state_reg == S_EXEC)
    `MPP_ASSERT_IMP(a_offscreen_no_write, (state_reg == S_EXEC) && !inside_reg,
                    !bm_we && !cell_we)
    `MPP_ASSERT_IMP(a_cell_write_with_bitmap, (state_reg != S_CLEAR) && cell_we, bm_we)
    `MPP_ASSERT_NEXT(a_done_gives_result, done, result_valid)

endmodule
